// File: design/gtl_pkg.sv
// Shared types, character codes and the letter mapping ROM of the transliterator.
package gtl_pkg;

  // Item kinds on the input channel
  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // ISO-8859-7 codes with special handling
  localparam logic [7:0] GR_MU_UC   = 8'd204;
  localparam logic [7:0] GR_NU_UC   = 8'd205;
  localparam logic [7:0] GR_MU_LC   = 8'd236;
  localparam logic [7:0] GR_NU_LC   = 8'd237;
  localparam logic [7:0] GR_PI_UC   = 8'd208;
  localparam logic [7:0] GR_PI_LC   = 8'd240;
  localparam logic [7:0] GR_TAU_UC  = 8'd212;
  localparam logic [7:0] GR_TAU_LC  = 8'd244;
  localparam logic [7:0] GR_XI_UC   = 8'd206;
  localparam logic [7:0] GR_PSI_UC  = 8'd216;
  localparam logic [7:0] GR_XI_LC   = 8'd238;
  localparam logic [7:0] GR_PSI_LC  = 8'd248;
  localparam logic [7:0] CH_BSLASH  = 8'd92;

  // Latin codes produced by special cases
  localparam logic [7:0] LT_NEWLINE = 8'd10;
  localparam logic [7:0] LT_S_UC    = 8'd83;
  localparam logic [7:0] LT_S_LC    = 8'd115;
  localparam logic [7:0] LT_B_UC    = 8'd66;
  localparam logic [7:0] LT_B_LC    = 8'd98;
  localparam logic [7:0] LT_D_UC    = 8'd68;
  localparam logic [7:0] LT_D_LC    = 8'd100;

  // Results per item and depth of the front-to-back queue
  localparam int MAX_RESULTS   = 3;
  localparam int QUEUE_DEPTH   = 2;

  // One classified item: up to three bytes and how many are valid
  typedef struct packed {
    logic [1:0]                   cnt;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
  } gtl_entry_t;

  // Letter ROM; zero means no mapping
  function automatic logic [7:0] rom_main(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      8'd182: r = 8'd65;   8'd184: r = 8'd69;   8'd185: r = 8'd72;
      8'd186: r = 8'd73;   8'd188: r = 8'd79;   8'd190: r = 8'd89;
      8'd191: r = 8'd87;   8'd192: r = 8'd105;  8'd193: r = 8'd65;
      8'd194: r = 8'd86;   8'd195: r = 8'd71;   8'd196: r = 8'd68;
      8'd197: r = 8'd69;   8'd198: r = 8'd90;   8'd199: r = 8'd72;
      8'd200: r = 8'd56;   8'd201: r = 8'd73;   8'd202: r = 8'd75;
      8'd203: r = 8'd76;   8'd204: r = 8'd77;   8'd205: r = 8'd78;
      8'd206: r = 8'd75;   8'd207: r = 8'd79;   8'd208: r = 8'd80;
      8'd209: r = 8'd82;   8'd211: r = 8'd83;   8'd212: r = 8'd84;
      8'd213: r = 8'd89;   8'd214: r = 8'd70;   8'd215: r = 8'd88;
      8'd216: r = 8'd80;   8'd217: r = 8'd87;   8'd218: r = 8'd73;
      8'd219: r = 8'd89;   8'd220: r = 8'd97;   8'd221: r = 8'd101;
      8'd222: r = 8'd104;  8'd223: r = 8'd105;  8'd224: r = 8'd121;
      8'd225: r = 8'd97;   8'd226: r = 8'd118;  8'd227: r = 8'd103;
      8'd228: r = 8'd100;  8'd229: r = 8'd101;  8'd230: r = 8'd122;
      8'd231: r = 8'd104;  8'd232: r = 8'd56;   8'd233: r = 8'd105;
      8'd234: r = 8'd107;  8'd235: r = 8'd108;  8'd236: r = 8'd109;
      8'd237: r = 8'd110;  8'd238: r = 8'd107;  8'd239: r = 8'd111;
      8'd240: r = 8'd112;  8'd241: r = 8'd114;  8'd242: r = 8'd115;
      8'd243: r = 8'd115;  8'd244: r = 8'd116;  8'd245: r = 8'd121;
      8'd246: r = 8'd102;  8'd247: r = 8'd120;  8'd248: r = 8'd112;
      8'd249: r = 8'd119;  8'd250: r = 8'd105;  8'd251: r = 8'd121;
      8'd252: r = 8'd111;  8'd253: r = 8'd121;  8'd254: r = 8'd119;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Mapped letter, or the byte itself when the ROM has no entry
  function automatic logic [7:0] map_byte(input logic [7:0] b);
    logic [7:0] r;
    r = rom_main(b);
    return (r != 8'd0) ? r : b;
  endfunction

  function automatic logic is_mn(input logic [7:0] b);
    return (b == GR_MU_UC) || (b == GR_NU_UC) || (b == GR_MU_LC) || (b == GR_NU_LC);
  endfunction

endpackage

// File: design/gtl_in_if.sv
// Input channel: one command item (data byte or end of stream).
interface gtl_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_byte;

  modport source (output valid, output func, output in_byte, input ready);
  modport sink   (input valid, input func, input in_byte, output ready);
endinterface

// File: design/gtl_out_if.sv
// Result channel: one Latin byte per item.
interface gtl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: design/gtl_front.sv
// Front end: accepts items, tracks the pending M/N letter and builds result entries.
module gtl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [7:0]          in_byte,
  input  logic                q_full,
  output logic                push,
  output gtl_pkg::gtl_entry_t push_entry
);

  logic       pend_valid_r, pend_valid_nxt;
  logic [7:0] pend_letter_r, pend_letter_nxt;
  logic       accept;

  // Plain-byte classification
  logic [1:0] pl_cnt;
  logic [7:0] pl0, pl1;
  logic       pl_hold;

  logic       m_case, n_case, is_pi, is_tau;
  gtl_pkg::gtl_entry_t ent;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // How a byte is handled with nothing held
  always_comb begin
    pl_cnt  = 2'd1;
    pl0     = gtl_pkg::map_byte(in_byte);
    pl1     = 8'd0;
    pl_hold = 1'b0;
    if (gtl_pkg::is_mn(in_byte)) begin
      pl_cnt  = 2'd0;
      pl_hold = 1'b1;
    end else if (in_byte == gtl_pkg::GR_XI_UC || in_byte == gtl_pkg::GR_PSI_UC) begin
      pl_cnt = 2'd2;
      pl1    = gtl_pkg::LT_S_UC;
    end else if (in_byte == gtl_pkg::GR_XI_LC || in_byte == gtl_pkg::GR_PSI_LC) begin
      pl_cnt = 2'd2;
      pl1    = gtl_pkg::LT_S_LC;
    end else if (in_byte == gtl_pkg::CH_BSLASH) begin
      pl0 = gtl_pkg::LT_NEWLINE;
    end
  end

  assign m_case = (pend_letter_r == gtl_pkg::GR_MU_UC) || (pend_letter_r == gtl_pkg::GR_MU_LC);
  assign n_case = (pend_letter_r == gtl_pkg::GR_NU_UC) || (pend_letter_r == gtl_pkg::GR_NU_LC);
  assign is_pi  = (in_byte == gtl_pkg::GR_PI_UC) || (in_byte == gtl_pkg::GR_PI_LC);
  assign is_tau = (in_byte == gtl_pkg::GR_TAU_UC) || (in_byte == gtl_pkg::GR_TAU_LC);

  // Combine the held letter with the new item
  always_comb begin
    ent             = '0;
    pend_valid_nxt  = pend_valid_r;
    pend_letter_nxt = pend_letter_r;
    if (in_func == gtl_pkg::FUNC_END) begin
      if (pend_valid_r) begin
        ent.cnt      = 2'd1;
        ent.bytes[0] = gtl_pkg::rom_main(pend_letter_r);
      end
      pend_valid_nxt = 1'b0;
    end else if (pend_valid_r) begin
      if (in_byte == pend_letter_r) begin
        ent.cnt      = 2'd1;
        ent.bytes[0] = gtl_pkg::rom_main(pend_letter_r);
      end else if (m_case && is_pi) begin
        ent.cnt        = 2'd1;
        ent.bytes[0]   = (pend_letter_r == gtl_pkg::GR_MU_UC) ? gtl_pkg::LT_B_UC
                                                              : gtl_pkg::LT_B_LC;
        pend_valid_nxt = 1'b0;
      end else if (n_case && is_tau) begin
        ent.cnt        = 2'd1;
        ent.bytes[0]   = (pend_letter_r == gtl_pkg::GR_NU_UC) ? gtl_pkg::LT_D_UC
                                                              : gtl_pkg::LT_D_LC;
        pend_valid_nxt = 1'b0;
      end else begin
        // flush the held letter, then the byte on its own
        ent.cnt        = 2'd1 + pl_cnt;
        ent.bytes[0]   = gtl_pkg::rom_main(pend_letter_r);
        ent.bytes[1]   = pl0;
        ent.bytes[2]   = pl1;
        pend_valid_nxt = pl_hold;
        if (pl_hold) begin
          pend_letter_nxt = in_byte;
        end
      end
    end else begin
      ent.cnt      = pl_cnt;
      ent.bytes[0] = pl0;
      ent.bytes[1] = pl1;
      if (pl_hold) begin
        pend_valid_nxt  = 1'b1;
        pend_letter_nxt = in_byte;
      end
    end
  end

  assign push       = accept && (ent.cnt != 2'd0);
  assign push_entry = ent;

  // Pending letter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r  <= 1'b0;
      pend_letter_r <= 8'd0;
    end else if (accept) begin
      pend_valid_r  <= pend_valid_nxt;
      pend_letter_r <= pend_letter_nxt;
    end
  end

  // A held letter is always M or N
  a_pend_is_mn: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> gtl_pkg::is_mn(pend_letter_r))
    else $error("pending letter is not M or N");

  // End of stream leaves nothing held
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == gtl_pkg::FUNC_END) |=> !pend_valid_r)
    else $error("pending letter survived end of stream");

endmodule

// File: design/gtl_queue.sv
// Short register queue between the front end and the output sequencer.
module gtl_queue #(
  parameter int DEPTH = gtl_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gtl_pkg::gtl_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output gtl_pkg::gtl_entry_t head_entry
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  gtl_pkg::gtl_entry_t slots_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count_r == CntW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slots_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

// File: design/gtl_back.sv
// Back end: steps through each queued entry and drives one byte per output item.
module gtl_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  gtl_pkg::gtl_entry_t head_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [1:0] idx_r, idx_nxt;
  logic       load, is_last;

  assign load    = head_valid && (!out_valid_r || out_ready);
  assign is_last = (idx_r == head_entry.cnt - 2'd1);
  assign pop     = load && is_last;
  assign idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;

  // Byte index within the head entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (load) begin
      idx_r <= idx_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= head_entry.bytes[idx_r];
      out_last_r <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // Mid-entry index only exists while the entry is still queued
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> (head_valid && idx_r < head_entry.cnt))
    else $error("byte index outside head entry");

endmodule

// File: design/greek_to_latin_transliterator.sv
// Top level of the ISO-8859-7 Greek to Latin transliterator.
// Each input item is either a data byte (func 0) or an end-of-stream marker (func 1)
// and yields zero to three Latin bytes; the final byte of each item's results carries
// last_of_run. M, m, N and n are held back one item so that M+pi and N+tau can become
// B/b and D/d; an end-of-stream item releases a held letter. The front end takes one
// item per cycle while the queue (QueueDepth entries) has room, and the output
// register sends one byte per cycle while out_ready is high; an item that produces
// nothing is still accepted but pushes no entry. The first result byte passes
// through a queue slot and then the output register before it is presented.
module greek_to_latin_transliterator #(
  parameter int QueueDepth = gtl_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  gtl_in_if.sink    in_ch,
  gtl_out_if.source out_ch
);

  logic                push, q_full, pop, head_valid;
  gtl_pkg::gtl_entry_t push_entry, head_entry;

  gtl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_func    (in_ch.func),
    .in_byte    (in_ch.in_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  gtl_queue #(.DEPTH(QueueDepth)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  gtl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .out_last   (out_ch.last_of_run)
  );

endmodule
